FILE: src/segment_intersection_defines.svh
// Assertion macros for the segment intersection block.
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define SI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SI_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SI_ASSERT(label, clk, rst, prop, msg)
`define SI_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: src/segi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared widths for the block and its divider cells.
// ----------------------------------------------------------------------------
package segi_pkg;
   localparam int OutWidth = 18;
   localparam int TolWidth = 15;
   localparam int ClampShift = 40;
   localparam int QWidth = ClampShift + 2;
endpackage
`default_nettype wire

FILE: src/segi_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step for two quotients; registers the partial state.
// ----------------------------------------------------------------------------
module segi_div_cell #(
   parameter int NumWidth = 80,
   parameter int DenWidth = 40,
   parameter int QW = 42,
   parameter int BitIdx = 0,
   parameter int TagWidth = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                stall,
   input  wire logic                v_in,
   input  wire logic [NumWidth-1:0] rx_in,
   input  wire logic [NumWidth-1:0] ry_in,
   input  wire logic [DenWidth-1:0] den_in,
   input  wire logic [QW-1:0]       qx_in,
   input  wire logic [QW-1:0]       qy_in,
   input  wire logic [TagWidth-1:0] tag_in,
   output logic                     v_out,
   output logic [NumWidth-1:0]      rx_out,
   output logic [NumWidth-1:0]      ry_out,
   output logic [DenWidth-1:0]      den_out,
   output logic [QW-1:0]            qx_out,
   output logic [QW-1:0]            qy_out,
   output logic [TagWidth-1:0]      tag_out
);
   logic [NumWidth-1:0] dsh;
   logic                bx, by;

   assign dsh = NumWidth'(den_in) << BitIdx;
   assign bx  = rx_in >= dsh;
   assign by  = ry_in >= dsh;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_out <= 1'b0;
      end else if (!stall) begin
         v_out <= v_in;
      end
      if (!stall) begin
         rx_out  <= bx ? rx_in - dsh : rx_in;
         ry_out  <= by ? ry_in - dsh : ry_in;
         den_out <= den_in;
         qx_out  <= qx_in | (QW'(bx) << BitIdx);
         qy_out  <= qy_in | (QW'(by) << BitIdx);
         tag_out <= tag_in;
      end
   end
endmodule
`default_nettype wire

FILE: src/segment_intersection.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment intersection
// Finds where the lines through two 2D segments cross and tests the hit.
// ----------------------------------------------------------------------------
// Each request transaction carries two segments as signed Q8.8 coordinates;
// each response transaction returns hit, parallel and the crossing point.
// Front end: stage one forms differences, stage two the 2x2 products, stage
// three the determinant and cross products, stage four the numerator
// products, stage five the numerators, magnitudes and the quotient limit.
// A chain of 41 divider cells then retires one quotient bit each, and a
// final stage applies sign, saturation and the box tests.
// One transaction is accepted every cycle while the pipe is not stalled, set
// by the one-step divider cells.
// When the receiver stalls the whole pipe holds, and req_ready falls only
// while the output register is full and not being taken.
// Reset empties the pipe and sets the tolerance to one LSB.
// ----------------------------------------------------------------------------
`include "segment_intersection_defines.svh"
module segment_intersection #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [COORD_WIDTH-1:0]  req_a_start_x,
   input  wire logic [COORD_WIDTH-1:0]  req_a_start_y,
   input  wire logic [COORD_WIDTH-1:0]  req_a_end_x,
   input  wire logic [COORD_WIDTH-1:0]  req_a_end_y,
   input  wire logic [COORD_WIDTH-1:0]  req_b_start_x,
   input  wire logic [COORD_WIDTH-1:0]  req_b_start_y,
   input  wire logic [COORD_WIDTH-1:0]  req_b_end_x,
   input  wire logic [COORD_WIDTH-1:0]  req_b_end_y,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_hit,
   output logic                         rsp_parallel,
   output logic signed [segi_pkg::OutWidth-1:0] rsp_cross_x,
   output logic signed [segi_pkg::OutWidth-1:0] rsp_cross_y,
   input  wire logic                    csr_we,
   input  wire logic [segi_pkg::TolWidth-1:0] csr_wdata
);
   import segi_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;
   localparam int MW  = 2 * DW + 1;
   localparam int PW  = 2 * CW + 1;
   localparam int TW  = PW + DW + 1;
   localparam int NW  = TW + 1;
   localparam int DEN = MW;
   localparam int TGW = 2 + 8 * CW;
   localparam int NC  = ClampShift + 1;
   localparam int RW  = (NW > DEN + ClampShift + 1) ? NW : DEN + ClampShift + 1;

   logic stall;
   logic [TolWidth-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TolWidth'(1);
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   assign stall     = rsp_valid && !rsp_ready;
   assign req_ready = !stall;

   // stage 1
   logic v1_ff;
   logic signed [CW-1:0] c_ff [8];
   logic signed [DW-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (!stall) v1_ff <= req_valid;
      if (!stall) begin
         c_ff[0] <= req_a_start_x; c_ff[1] <= req_a_start_y;
         c_ff[2] <= req_a_end_x;   c_ff[3] <= req_a_end_y;
         c_ff[4] <= req_b_start_x; c_ff[5] <= req_b_start_y;
         c_ff[6] <= req_b_end_x;   c_ff[7] <= req_b_end_y;
         dxa_ff <= DW'($signed(req_a_start_x)) - DW'($signed(req_a_end_x));
         dya_ff <= DW'($signed(req_a_start_y)) - DW'($signed(req_a_end_y));
         dxb_ff <= DW'($signed(req_b_start_x)) - DW'($signed(req_b_end_x));
         dyb_ff <= DW'($signed(req_b_start_y)) - DW'($signed(req_b_end_y));
      end
   end

   // stage 2: six products
   logic v2_ff;
   logic signed [CW-1:0] c2_ff [8];
   logic signed [DW-1:0] dxa2_ff, dya2_ff, dxb2_ff, dyb2_ff;
   logic signed [MW-1:0] m1_ff, m2_ff;
   logic signed [PW-1:0] pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (!stall) v2_ff <= v1_ff;
      if (!stall) begin
         c2_ff <= c_ff;
         dxa2_ff <= dxa_ff; dya2_ff <= dya_ff; dxb2_ff <= dxb_ff; dyb2_ff <= dyb_ff;
         m1_ff  <= MW'(dxa_ff * dyb_ff);
         m2_ff  <= MW'(dya_ff * dxb_ff);
         pa1_ff <= PW'(c_ff[0] * c_ff[3]);
         pa2_ff <= PW'(c_ff[1] * c_ff[2]);
         pb1_ff <= PW'(c_ff[4] * c_ff[7]);
         pb2_ff <= PW'(c_ff[5] * c_ff[6]);
      end
   end

   // stage 3: determinant and cross terms
   logic v3_ff;
   logic signed [CW-1:0] c3_ff [8];
   logic signed [MW-1:0] d3_ff;
   logic signed [DW-1:0] dxa3_ff, dya3_ff, dxb3_ff, dyb3_ff;
   logic signed [PW-1:0] pa3_ff, pb3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (!stall) v3_ff <= v2_ff;
      if (!stall) begin
         c3_ff <= c2_ff;
         dxa3_ff <= dxa2_ff; dya3_ff <= dya2_ff; dxb3_ff <= dxb2_ff; dyb3_ff <= dyb2_ff;
         d3_ff  <= m1_ff - m2_ff;
         pa3_ff <= pa1_ff - pa2_ff;
         pb3_ff <= pb1_ff - pb2_ff;
      end
   end

   // stage 4: four wide products
   logic v4_ff;
   logic signed [CW-1:0] c4_ff [8];
   logic signed [MW-1:0] d4_ff;
   logic signed [TW-1:0] t1x_ff, t2x_ff, t1y_ff, t2y_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (!stall) v4_ff <= v3_ff;
      if (!stall) begin
         c4_ff <= c3_ff;
         d4_ff <= d3_ff;
         t1x_ff <= TW'(pa3_ff * dxb3_ff);
         t2x_ff <= TW'(dxa3_ff * pb3_ff);
         t1y_ff <= TW'(pa3_ff * dyb3_ff);
         t2y_ff <= TW'(dya3_ff * pb3_ff);
      end
   end

   // stage 5: magnitudes, signs, clamp flags
   logic signed [NW-1:0] nx, ny;
   logic [NW-1:0]  mx, my;
   logic [DEN-1:0] md;
   logic [RW-1:0]  lim;
   assign nx  = NW'(t1x_ff) - NW'(t2x_ff);
   assign ny  = NW'(t1y_ff) - NW'(t2y_ff);
   assign mx  = nx[NW-1] ? NW'(-nx) : NW'(nx);
   assign my  = ny[NW-1] ? NW'(-ny) : NW'(ny);
   assign md  = d4_ff[MW-1] ? DEN'(-d4_ff) : DEN'(d4_ff);
   assign lim = RW'(md) << ClampShift;

   logic v5_ff;
   logic [RW-1:0]  r5x_ff, r5y_ff;
   logic [DEN-1:0] md5_ff;
   logic [TGW-1:0] tg5_ff;
   logic [3:0]     fl5_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (!stall) v5_ff <= v4_ff;
      if (!stall) begin
         r5x_ff <= RW'(mx);
         r5y_ff <= RW'(my);
         md5_ff <= md;
         fl5_ff <= {RW'(mx) >= lim, RW'(my) >= lim,
                    nx[NW-1] ^ d4_ff[MW-1], ny[NW-1] ^ d4_ff[MW-1]};
         tg5_ff <= {d4_ff == '0, 1'b0, c4_ff[0], c4_ff[1], c4_ff[2], c4_ff[3],
                    c4_ff[4], c4_ff[5], c4_ff[6], c4_ff[7]};
      end
   end

   // divider chain
   logic           cv  [NC+1];
   logic [RW-1:0]  crx [NC+1];
   logic [RW-1:0]  cry [NC+1];
   logic [DEN-1:0] cd  [NC+1];
   logic [QWidth-1:0] cqx [NC+1];
   logic [QWidth-1:0] cqy [NC+1];
   logic [TGW+3:0] ctg [NC+1];
   assign cv[0] = v5_ff; assign crx[0] = r5x_ff; assign cry[0] = r5y_ff;
   assign cd[0] = md5_ff; assign cqx[0] = '0; assign cqy[0] = '0;
   assign ctg[0] = {fl5_ff, tg5_ff};

   for (genvar g = 0; g < NC; g++) begin : g_cell
      segi_div_cell #(.NumWidth(RW), .DenWidth(DEN), .QW(QWidth),
                      .BitIdx(ClampShift - g), .TagWidth(TGW + 4)) u_cell (
         .clock(clock), .reset(reset), .stall(stall),
         .v_in(cv[g]), .rx_in(crx[g]), .ry_in(cry[g]), .den_in(cd[g]),
         .qx_in(cqx[g]), .qy_in(cqy[g]), .tag_in(ctg[g]),
         .v_out(cv[g+1]), .rx_out(crx[g+1]), .ry_out(cry[g+1]), .den_out(cd[g+1]),
         .qx_out(cqx[g+1]), .qy_out(cqy[g+1]), .tag_out(ctg[g+1]));
   end

   // final stage
   logic [TGW+3:0] tf;
   logic signed [CW-1:0] fx1, fy1, fx2, fy2, fx3, fy3, fx4, fy4;
   logic [QWidth-1:0] qxm, qym;
   logic signed [QWidth:0] qx, qy;
   logic signed [QWidth:0] tl;
   logic par, hit_c;
   assign tf  = ctg[NC];
   assign par = tf[TGW-1];
   assign {fx1, fy1, fx2, fy2, fx3, fy3, fx4, fy4} = tf[8*CW-1:0];
   assign qxm = tf[TGW+3] ? (QWidth'(1) << ClampShift) : cqx[NC];
   assign qym = tf[TGW+2] ? (QWidth'(1) << ClampShift) : cqy[NC];
   assign qx  = tf[TGW+1] ? -$signed({1'b0, qxm}) : $signed({1'b0, qxm});
   assign qy  = tf[TGW]   ? -$signed({1'b0, qym}) : $signed({1'b0, qym});
   assign tl  = $signed({1'b0, (QWidth)'(tol_ff)});

   function automatic logic inbox(input logic signed [QWidth:0] v,
                                  input logic signed [CW-1:0] p,
                                  input logic signed [CW-1:0] q,
                                  input logic signed [QWidth:0] t);
      logic signed [QWidth:0] lo, hi;
      lo = (p < q) ? (QWidth+1)'(p) : (QWidth+1)'(q);
      hi = (p < q) ? (QWidth+1)'(q) : (QWidth+1)'(p);
      return (v + t >= lo) && (v - t <= hi);
   endfunction

   function automatic logic [OutWidth-1:0] sat(input logic signed [QWidth:0] v);
      if (v > (QWidth+1)'(131071)) return OutWidth'(131071);
      if (v < -(QWidth+1)'(131072)) return OutWidth'(-131072);
      return OutWidth'(v);
   endfunction

   assign hit_c = inbox(qx, fx1, fx2, tl) && inbox(qx, fx3, fx4, tl) &&
                  inbox(qy, fy1, fy2, tl) && inbox(qy, fy3, fy4, tl);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (!stall) rsp_valid <= cv[NC];
      if (!stall) begin
         rsp_parallel <= par;
         rsp_hit      <= !par && hit_c;
         rsp_cross_x  <= par ? '0 : sat(qx);
         rsp_cross_y  <= par ? '0 : sat(qy);
      end
   end

   `SI_ASSERT(a_hold, clock, reset, stall |=> rsp_valid, "response dropped under stall")
   `SI_ASSERT(a_par, clock, reset, rsp_valid && rsp_parallel |-> !rsp_hit, "parallel hit")
   `SI_ASSERT(a_parz, clock, reset, rsp_valid && rsp_parallel |-> rsp_cross_x == '0, "parallel x")
   `SI_ASSERT_NR(a_rst, clock, $past(reset) |-> !rsp_valid, "valid after reset")
endmodule
`default_nettype wire

FILE: dv/tb_segment_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection testbench
// Drives random and corner-case segment pairs through the block, predicts the
// crossing point and hit flag of each, and compares every response in order.
// ----------------------------------------------------------------------------
module tb_segment_intersection;
   import segi_pkg::*;

   typedef struct {
      logic signed [15:0] c [8];
   } seg_pair_type;

   typedef struct {
      logic hit;
      logic parallel;
      logic signed [OutWidth-1:0] x;
      logic signed [OutWidth-1:0] y;
   } crossing_type;

   int errors = 0;

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d, want %0d", what, got, want);
   endtask

   class crossing_board;
      crossing_type pending[$];
      logic [TolWidth-1:0] slack = 1;

      function automatic longint quotient(input longint d, input logic signed [127:0] num);
         logic signed [127:0] q;
         longint lim;
         lim = longint'(1) <<< ClampShift;
         q = num / d;
         if (q > lim) q = lim;
         if (q < -lim) q = -lim;
         return longint'(q);
      endfunction

      function automatic bit inside_box(input longint v, input longint p, input longint q,
                                        input longint t);
         longint lo, hi;
         lo = p < q ? p : q;
         hi = p < q ? q : p;
         return (v + t >= lo) && (v - t <= hi);
      endfunction

      function automatic logic signed [OutWidth-1:0] clip(input longint v);
         if (v > 131071) return OutWidth'(131071);
         if (v < -131072) return OutWidth'(-131072);
         return OutWidth'(v);
      endfunction

      function void note(input seg_pair_type s);
         longint x1, y1, x2, y2, x3, y3, x4, y4, dxa, dya, dxb, dyb, d, pa, pb, cx, cy, t;
         crossing_type r;
         x1 = s.c[0]; y1 = s.c[1]; x2 = s.c[2]; y2 = s.c[3];
         x3 = s.c[4]; y3 = s.c[5]; x4 = s.c[6]; y4 = s.c[7];
         dxa = x1 - x2; dya = y1 - y2; dxb = x3 - x4; dyb = y3 - y4;
         d = dxa * dyb - dya * dxb;
         r = '{hit: 0, parallel: 1, x: 0, y: 0};
         if (d != 0) begin
            pa = x1 * y2 - y1 * x2;
            pb = x3 * y4 - y3 * x4;
            cx = quotient(d, 128'(pa) * 128'(dxb) - 128'(dxa) * 128'(pb));
            cy = quotient(d, 128'(pa) * 128'(dyb) - 128'(dya) * 128'(pb));
            t = slack;
            r.parallel = 0;
            r.hit = inside_box(cx, x1, x2, t) && inside_box(cx, x3, x4, t) &&
                    inside_box(cy, y1, y2, t) && inside_box(cy, y3, y4, t);
            r.x = clip(cx);
            r.y = clip(cy);
         end
         pending.push_back(r);
      endfunction

      task check(input logic hit, input logic par,
                 input logic signed [OutWidth-1:0] x,
                 input logic signed [OutWidth-1:0] y);
         crossing_type w;
         if (pending.size() == 0) begin
            report("unexpected response", 0, 0);
            return;
         end
         w = pending.pop_front();
         if (hit !== w.hit) report("hit", hit, w.hit);
         if (par !== w.parallel) report("parallel", par, w.parallel);
         if (x !== w.x) report("cross_x", x, w.x);
         if (y !== w.y) report("cross_y", y, w.y);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic rsp_ready = 0;
   logic req_ready;
   logic [15:0] req_c [8];
   logic rsp_valid, rsp_hit, rsp_parallel;
   logic signed [OutWidth-1:0] rsp_cross_x, rsp_cross_y;
   logic csr_we = 0;
   logic [TolWidth-1:0] csr_wdata = 0;
   crossing_board board = new();
   longint cycles = 0;
   bit stall_mode = 0;

   initial foreach (req_c[i]) req_c[i] = 0;

   always #5 clock = ~clock;

   segment_intersection u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_start_x(req_c[0]), .req_a_start_y(req_c[1]),
      .req_a_end_x(req_c[2]), .req_a_end_y(req_c[3]),
      .req_b_start_x(req_c[4]), .req_b_start_y(req_c[5]),
      .req_b_end_x(req_c[6]), .req_b_end_y(req_c[7]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_parallel(rsp_parallel),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready)
         board.check(rsp_hit, rsp_parallel, rsp_cross_x, rsp_cross_y);
      if (stall_mode) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= 1;
      if (($urandom_range(0, 199)) == 0) stall_mode <= ~stall_mode;
   end

   task automatic send(input seg_pair_type s);
      @(posedge clock);
      req_valid <= 1;
      foreach (req_c[i]) req_c[i] <= s.c[i];
      do @(posedge clock); while (!req_ready);
      board.note(s);
      req_valid <= 0;
   endtask

   // Keeps valid high across a burst so back-to-back transactions occur.
   task automatic send_burst(input seg_pair_type s[$]);
      foreach (s[k]) begin
         if (k == 0) @(posedge clock);
         req_valid <= 1;
         foreach (req_c[i]) req_c[i] <= s[k].c[i];
         do @(posedge clock); while (!req_ready);
         board.note(s[k]);
      end
      req_valid <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_slack(input logic [TolWidth-1:0] v);
      @(posedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      board.slack = v;
   endtask

   function automatic seg_pair_type rand_pair(input int mode);
      seg_pair_type s;
      int r;
      r = $urandom_range(1, 4096);
      foreach (s.c[i]) begin
         case (mode)
            0: s.c[i] = 16'($urandom);
            1: s.c[i] = 16'($signed(16'($urandom_range(0, 2 * r))) - r);
            default: s.c[i] = 16'($signed(16'($urandom_range(0, 64))) - 32);
         endcase
      end
      if (mode == 2 && $urandom_range(0, 3) == 0) begin
         s.c[6] = s.c[4] + (s.c[2] - s.c[0]);
         s.c[7] = s.c[5] + (s.c[3] - s.c[1]);
      end
      return s;
   endfunction

   seg_pair_type s;
   seg_pair_type burst[$];
   logic signed [15:0] ext [4];

   initial begin
      ext = '{-32768, 32767, 0, -1};
      repeat (5) @(posedge clock);
      reset <= 0;
      s.c = '{0, 0, 256, 256, 0, 256, 256, 0};
      send(s);
      s.c = '{0, 0, 256, 0, 0, 256, 256, 256};
      send(s);
      s.c = '{0, 0, 256, 256, 512, 512, 768, 768};
      send(s);
      s.c = '{5, 5, 5, 5, 0, 0, 256, 256};
      send(s);
      s.c = '{0, 0, 256, 0, 257, -256, 257, 256};
      send(s);
      s.c = '{0, 0, 256, 0, 258, -256, 258, 256};
      send(s);
      s.c = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768};
      send(s);
      s.c = '{-32768, 32767, 32767, 32766, 32767, -32768, -32768, -32767};
      send(s);
      s.c = '{-32768, 0, 32767, 1, -32768, 1, 32767, 3};
      send(s);
      for (int k = 0; k < 8; k++) begin
         foreach (s.c[i]) s.c[i] = ext[$urandom_range(0, 3)];
         send(s);
      end
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_slack(TolWidth'(0));
            1: set_slack(15'h7FFF);
            2: set_slack(TolWidth'(256));
            default: set_slack(TolWidth'($urandom_range(0, 32767)));
         endcase
         for (int n = 0; n < 200;) begin
            int len;
            len = $urandom_range(1, 12);
            burst = {};
            for (int k = 0; k < len; k++) burst.push_back(rand_pair($urandom_range(0, 2)));
            send_burst(burst);
            n += len;
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge clock);
         end
         drain();
      end
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
